### src/kgn_pkg.sv
package kgn_pkg;

   localparam int KGN_MAX_ROWS = 64;
   localparam int KGN_MAX_COLS = 16;
   localparam int MUL_W        = 66;

   typedef enum logic [2:0] {
      OP_LOAD_COEF   = 3'd0,
      OP_LOAD_SAMPLE = 3'd1,
      OP_LOAD_KERNEL = 3'd2,
      OP_FIRST       = 3'd3,
      OP_SECOND      = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_ROWS  = 2'd0,
      CSR_COLS  = 2'd1,
      CSR_SIGMA = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_CLR_SUM,
      DP_RD_J,
      DP_CAP_XJK,
      DP_CAP_XJL,
      DP_CAP_I,
      DP_MUL_DK,
      DP_MUL_DL,
      DP_MUL_AK,
      DP_P1,
      DP_W,
      DP_MUL_PW,
      DP_ACC,
      DP_NEG,
      DP_SQ,
      DP_SUM,
      DP_DIV_INIT,
      DP_DIV_STEP,
      DP_SQRT_INIT,
      DP_SQRT_STEP
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      second;
      logic      same;
   } dp_cmd_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ERR,
      S_J_RDK,
      S_J_RDL,
      S_J_CAPL,
      S_I_RDK,
      S_I_RDL,
      S_I_MULK,
      S_I_TK,
      S_I_TL,
      S_I_P1,
      S_I_W,
      S_I_PW,
      S_I_ACC,
      S_J_NEG,
      S_J_SQ,
      S_J_SUM,
      S_DIV_INIT,
      S_DIV,
      S_SQRT_INIT,
      S_SQRT,
      S_DONE
   } ctrl_state_type;

   // clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [MUL_W-1:0] v);
      logic signed [31:0] r;
      if (v > MUL_W'(64'sh7FFF_FFFF)) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -MUL_W'(64'sh8000_0000)) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // shift right 16, round half away from zero, then saturate
   function automatic logic signed [31:0] sat_rnd(input logic signed [MUL_W-1:0] v);
      logic [MUL_W-1:0]        m;
      logic signed [MUL_W-1:0] r;
      if (v < 0) begin
         m = MUL_W'(-v);
         m = (m + MUL_W'(32768)) >> 16;
         r = -$signed(m);
      end else begin
         r = (v + MUL_W'(32768)) >>> 16;
      end
      return sat32(r);
   endfunction

endpackage

### src/kgn_ram.sv
module kgn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

### src/kgn_ctrl.sv
module kgn_ctrl #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 16,
   parameter int RW       = 6,
   parameter int NW       = 7,
   parameter int PW       = 5,
   parameter int SUM_W    = 53
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_start,
   input  logic [2:0]              req_opcode,
   input  logic [3:0]              req_first_col,
   input  logic [3:0]              req_second_col,
   input  logic [NW-1:0]           n_rows,
   input  logic [PW-1:0]           n_cols,
   output logic                    busy,
   output kgn_pkg::dp_cmd_type     cmd,
   output logic [RW-1:0]           row_i,
   output logic [RW-1:0]           row_j,
   output logic [3:0]              col_sel,
   output logic                    rsp_valid,
   output logic                    rsp_status
);
   import kgn_pkg::*;

   localparam int STW = $clog2(SUM_W + 1);

   ctrl_state_type  state_ff, state_in;
   logic [RW-1:0]   i_ff, i_in, j_ff, j_in;
   logic [3:0]      k_ff, k_in, l_ff, l_in;
   logic            second_ff, second_in;
   logic [STW-1:0]  cnt_ff, cnt_in;
   logic            accept, compute, bad_col, i_last, j_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      l_ff      <= l_in;
      second_ff <= second_in;
      cnt_ff    <= cnt_in;
   end

   assign accept  = req_start && (state_ff == S_IDLE);
   assign compute = (req_opcode == OP_FIRST) || (req_opcode == OP_SECOND);
   assign bad_col = (32'(req_first_col) >= 32'(n_cols)) ||
                    ((req_opcode == OP_SECOND) && (32'(req_second_col) >= 32'(n_cols)));
   assign i_last  = (NW'(i_ff) + NW'(1)) == n_rows;
   assign j_last  = (NW'(j_ff) + NW'(1)) == n_rows;

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      l_in       = l_ff;
      second_in  = second_ff;
      cnt_in     = cnt_ff;
      cmd.op     = DP_NOP;
      cmd.second = second_ff;
      cmd.same   = (k_ff == l_ff);
      col_sel    = k_ff;
      rsp_valid  = 1'b0;
      rsp_status = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && compute) begin
               k_in      = req_first_col;
               l_in      = req_second_col;
               second_in = (req_opcode == OP_SECOND);
               j_in      = '0;
               cmd.op    = DP_CLR_SUM;
               state_in  = bad_col ? S_ERR : S_J_RDK;
            end
         end
         S_ERR: begin
            rsp_valid  = 1'b1;
            rsp_status = 1'b1;
            state_in   = S_IDLE;
         end
         S_J_RDK: begin
            cmd.op   = DP_RD_J;
            state_in = S_J_RDL;
         end
         S_J_RDL: begin
            col_sel  = l_ff;
            cmd.op   = DP_CAP_XJK;
            state_in = S_J_CAPL;
         end
         S_J_CAPL: begin
            cmd.op   = DP_CAP_XJL;
            i_in     = '0;
            state_in = S_I_RDK;
         end
         S_I_RDK:  state_in = S_I_RDL;
         S_I_RDL: begin
            col_sel  = l_ff;
            cmd.op   = DP_CAP_I;
            state_in = S_I_MULK;
         end
         S_I_MULK: begin
            cmd.op   = DP_MUL_DK;
            state_in = S_I_TK;
         end
         S_I_TK: begin
            cmd.op   = DP_MUL_DL;
            state_in = S_I_TL;
         end
         S_I_TL: begin
            cmd.op   = DP_MUL_AK;
            state_in = S_I_P1;
         end
         S_I_P1: begin
            cmd.op   = DP_P1;
            state_in = second_ff ? S_I_W : S_I_PW;
         end
         S_I_W: begin
            cmd.op   = DP_W;
            state_in = S_I_PW;
         end
         S_I_PW: begin
            cmd.op   = DP_MUL_PW;
            state_in = S_I_ACC;
         end
         S_I_ACC: begin
            cmd.op = DP_ACC;
            if (i_last) begin
               state_in = S_J_NEG;
            end else begin
               i_in     = i_ff + RW'(1);
               state_in = S_I_RDK;
            end
         end
         S_J_NEG: begin
            cmd.op   = DP_NEG;
            state_in = S_J_SQ;
         end
         S_J_SQ: begin
            cmd.op   = DP_SQ;
            state_in = S_J_SUM;
         end
         S_J_SUM: begin
            cmd.op = DP_SUM;
            if (j_last) begin
               state_in = S_DIV_INIT;
            end else begin
               j_in     = j_ff + RW'(1);
               state_in = S_J_RDK;
            end
         end
         S_DIV_INIT: begin
            cmd.op   = DP_DIV_INIT;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = DP_DIV_STEP;
            cnt_in = cnt_ff + STW'(1);
            if (cnt_ff == STW'(SUM_W - 1)) begin
               state_in = S_SQRT_INIT;
            end
         end
         S_SQRT_INIT: begin
            cmd.op   = DP_SQRT_INIT;
            cnt_in   = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = DP_SQRT_STEP;
            cnt_in = cnt_ff + STW'(1);
            if (cnt_ff == STW'(31)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            rsp_valid = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign busy  = (state_ff != S_IDLE);
   assign row_i = i_ff;
   assign row_j = j_ff;
endmodule

### src/kgn_dp.sv
module kgn_dp #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 16,
   parameter int RW       = 6,
   parameter int NW       = 7,
   parameter int SUM_W    = 53
) (
   input  logic                clock,
   input  logic                load_accept,
   input  logic [2:0]          req_opcode,
   input  logic [5:0]          req_row,
   input  logic [5:0]          req_column,
   input  logic signed [31:0]  req_value,
   input  kgn_pkg::dp_cmd_type cmd,
   input  logic [RW-1:0]       row_i,
   input  logic [RW-1:0]       row_j,
   input  logic [3:0]          col_sel,
   input  logic [NW-1:0]       n_rows,
   input  logic [31:0]         inv_sigma2,
   output logic [31:0]         root
);
   import kgn_pkg::*;

   localparam int SD    = MAX_ROWS * MAX_COLS;
   localparam int KD    = MAX_ROWS * MAX_ROWS;
   localparam int SA_W  = $clog2(SD);
   localparam int KA_W  = $clog2(KD);
   localparam int ACC_W = 33 + RW;

   logic [RW-1:0]   coef_wa, coef_ra;
   logic [SA_W-1:0] samp_wa;
   logic [KA_W-1:0] kern_wa, kern_ra;
   logic            coef_we, samp_we, kern_we, row_ok;
   logic [31:0]     coef_rd, samp_rd, kern_rd;
   logic            use_row_j;
   logic [RW-1:0]   samp_row;

   logic signed [31:0]      xjk_ff, xjl_ff, a_ff, kv_ff, d_ff, dl_ff;
   logic signed [31:0]      tk_ff, tl_ff, p1_ff, w_ff, g_ff;
   logic signed [MUL_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [SUM_W-1:0]        sum_ff, dq_ff;
   logic [NW-1:0]           rem_ff;
   logic [63:0]             rad_ff;
   logic [31:0]             root_ff;
   logic [33:0]             srem_ff;

   logic signed [32:0]      mul_a, mul_b;
   logic signed [31:0]      pr_sr, w_sub;
   logic signed [MUL_W-1:0] diff_k, diff_l, neg_acc;
   logic [62:0]             sq_rnd;
   logic [NW:0]             rem_sh;
   logic [33:0]             trial_rem, trial;

   // loads
   assign row_ok  = 32'(req_row) < MAX_ROWS;
   assign coef_we = load_accept && (req_opcode == OP_LOAD_COEF) && row_ok;
   assign samp_we = load_accept && (req_opcode == OP_LOAD_SAMPLE) && row_ok &&
                    (32'(req_column) < MAX_COLS);
   assign kern_we = load_accept && (req_opcode == OP_LOAD_KERNEL) && row_ok &&
                    (32'(req_column) < MAX_ROWS);
   assign coef_wa = RW'(32'(req_row));
   assign samp_wa = SA_W'(32'(req_row) * MAX_COLS + 32'(req_column));
   assign kern_wa = KA_W'(32'(req_row) * MAX_ROWS + 32'(req_column));

   assign coef_ra = row_i;
   assign kern_ra = KA_W'(32'(row_i) * MAX_ROWS + 32'(row_j));

   kgn_ram #(.WIDTH(32), .DEPTH(MAX_ROWS)) u_coef (
      .clock(clock), .wr_en(coef_we), .wr_addr(coef_wa), .wr_data(req_value),
      .rd_addr(coef_ra), .rd_data(coef_rd));
   kgn_ram #(.WIDTH(32), .DEPTH(SD)) u_samp (
      .clock(clock), .wr_en(samp_we), .wr_addr(samp_wa), .wr_data(req_value),
      .rd_addr(SA_W'(32'(samp_row) * MAX_COLS + 32'(col_sel))), .rd_data(samp_rd));
   kgn_ram #(.WIDTH(32), .DEPTH(KD)) u_kern (
      .clock(clock), .wr_en(kern_we), .wr_addr(kern_wa), .wr_data(req_value),
      .rd_addr(kern_ra), .rd_data(kern_rd));

   // row j is read while the per-row preamble runs, row i otherwise
   assign use_row_j = (cmd.op == DP_RD_J) || (cmd.op == DP_CAP_XJK);
   assign samp_row  = use_row_j ? row_j : row_i;

   // shared multiplier operands
   always_comb begin
      unique case (cmd.op)
         DP_MUL_DK: begin mul_a = 33'(d_ff);  mul_b = $signed({1'b0, inv_sigma2}); end
         DP_MUL_DL: begin mul_a = 33'(dl_ff); mul_b = $signed({1'b0, inv_sigma2}); end
         DP_MUL_AK: begin mul_a = 33'(a_ff);  mul_b = 33'(kv_ff); end
         DP_P1:     begin mul_a = 33'(tk_ff); mul_b = 33'(tl_ff); end
         DP_MUL_PW: begin mul_a = 33'(p1_ff); mul_b = 33'(w_ff); end
         default:   begin mul_a = 33'(g_ff);  mul_b = 33'(g_ff); end
      endcase
   end

   assign pr_sr     = sat_rnd(prod_ff);
   assign w_sub     = sat32(MUL_W'(pr_sr) - MUL_W'($signed({1'b0, inv_sigma2})));
   assign diff_k    = MUL_W'(signed'(samp_rd)) - MUL_W'(xjk_ff);
   assign diff_l    = MUL_W'(signed'(samp_rd)) - MUL_W'(xjl_ff);
   assign neg_acc   = -MUL_W'(acc_ff);
   assign sq_rnd    = prod_ff[62:0] + 63'd32768;
   assign rem_sh    = {rem_ff, dq_ff[SUM_W-1]};
   assign trial_rem = {srem_ff[31:0], rad_ff[63:62]};
   assign trial     = {root_ff, 2'b01};

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         DP_CLR_SUM: sum_ff <= '0;
         DP_CAP_XJK: xjk_ff <= samp_rd;
         DP_CAP_XJL: begin
            xjl_ff <= samp_rd;
            acc_ff <= '0;
         end
         DP_CAP_I: begin
            a_ff  <= coef_rd;
            kv_ff <= kern_rd;
            d_ff  <= sat32(diff_k);
         end
         DP_MUL_DK: begin
            prod_ff <= mul_a * mul_b;
            dl_ff   <= sat32(diff_l);
         end
         DP_MUL_DL: begin
            tk_ff   <= pr_sr;
            prod_ff <= mul_a * mul_b;
         end
         DP_MUL_AK: begin
            tl_ff   <= pr_sr;
            prod_ff <= mul_a * mul_b;
         end
         DP_P1: begin
            p1_ff <= pr_sr;
            if (cmd.second) begin
               prod_ff <= mul_a * mul_b;
            end else begin
               w_ff <= tk_ff;
            end
         end
         DP_W:      w_ff <= cmd.same ? w_sub : pr_sr;
         DP_MUL_PW: prod_ff <= mul_a * mul_b;
         DP_ACC:    acc_ff <= acc_ff + ACC_W'(pr_sr);
         DP_NEG:    g_ff <= sat32(neg_acc);
         DP_SQ:     prod_ff <= mul_a * mul_b;
         DP_SUM:    sum_ff <= sum_ff + SUM_W'(sq_rnd[62:16]);
         DP_DIV_INIT: begin
            dq_ff  <= sum_ff;
            rem_ff <= '0;
         end
         DP_DIV_STEP: begin
            if (rem_sh >= (NW+1)'(n_rows)) begin
               rem_ff <= NW'(rem_sh - (NW+1)'(n_rows));
               dq_ff  <= {dq_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_ff <= NW'(rem_sh);
               dq_ff  <= {dq_ff[SUM_W-2:0], 1'b0};
            end
         end
         DP_SQRT_INIT: begin
            rad_ff  <= {1'b0, dq_ff[46:0], 16'd0};
            root_ff <= '0;
            srem_ff <= '0;
         end
         DP_SQRT_STEP: begin
            rad_ff <= {rad_ff[61:0], 2'b00};
            if (trial_rem >= trial) begin
               srem_ff <= trial_rem - trial;
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               srem_ff <= trial_rem;
               root_ff <= {root_ff[30:0], 1'b0};
            end
         end
         default: ;
      endcase
   end

   assign root = root_ff;
endmodule

### src/kernel_gradient_norm.sv
// Kernel gradient norm engine. Load items (opcodes 0..2) write the coefficient,
// sample and kernel stores in the cycle they are taken and give no result.
// A compute item (opcode 3 first order, 4 second order) walks every kernel
// entry of the rows in use through one shared 33x33 multiplier, with an
// extra weight step per entry for second order and a per-row negate, square
// and sum, then a restoring divide of 47+log2(MAX_ROWS) steps and a 32-step
// square root. Busy stays high throughout and start is ignored. A bad column
// answers in the cycle right after the item is taken, with status 1. The
// result is shown for exactly one cycle on rsp_valid and cannot be held off
// by the receiver. Store entries read by a compute item must have been
// loaded beforehand. Configuration writes are always taken (csr_ready tied
// high) and should only be issued while busy is low.
module kernel_gradient_norm #(
   parameter int MAX_ROWS = kgn_pkg::KGN_MAX_ROWS,
   parameter int MAX_COLS = kgn_pkg::KGN_MAX_COLS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_start,
   output logic               busy,
   input  logic [2:0]         req_opcode,
   input  logic [5:0]         req_row,
   input  logic [5:0]         req_column,
   input  logic signed [31:0] req_value,
   input  logic [3:0]         req_first_col,
   input  logic [3:0]         req_second_col,
   output logic               rsp_valid,
   output logic [31:0]        rsp_norm,
   output logic               rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import kgn_pkg::*;

   localparam int RW    = $clog2(MAX_ROWS);
   localparam int NW    = $clog2(MAX_ROWS + 1);
   localparam int PW    = $clog2(MAX_COLS + 1);
   localparam int SUM_W = 47 + RW;   // sum of squares over all rows

   logic [6:0]     rows_ff, rows_in;
   logic [4:0]     cols_ff, cols_in;
   logic [31:0]    sigma_ff, sigma_in;
   logic [NW-1:0]  n_rows;
   logic [PW-1:0]  n_cols;
   logic           load_accept, status;
   dp_cmd_type     cmd;
   logic [RW-1:0]  row_i, row_j;
   logic [3:0]     col_sel;
   logic [31:0]    root;

   // configuration registers
   always_comb begin
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      sigma_in = sigma_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ROWS:  rows_in  = csr_data[6:0];
            CSR_COLS:  cols_in  = csr_data[4:0];
            CSR_SIGMA: sigma_in = csr_data;
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= 7'd64;
         cols_ff  <= 5'd16;
         sigma_ff <= 32'd65536;
      end else begin
         rows_ff  <= rows_in;
         cols_ff  <= cols_in;
         sigma_ff <= sigma_in;
      end
   end

   assign csr_ready = 1'b1;

   // rows clamped to 1..MAX_ROWS, columns to at most MAX_COLS
   assign n_rows = (rows_ff == 7'd0) ? NW'(1) :
                   (32'(rows_ff) > MAX_ROWS) ? NW'(MAX_ROWS) : NW'(rows_ff);
   assign n_cols = (32'(cols_ff) > MAX_COLS) ? PW'(MAX_COLS) : PW'(cols_ff);

   assign load_accept = req_start && !busy;

   kgn_ctrl #(
      .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .RW(RW), .NW(NW), .PW(PW),
      .SUM_W(SUM_W)
   ) u_ctrl (
      .clock(clock), .reset(reset), .req_start(req_start),
      .req_opcode(req_opcode), .req_first_col(req_first_col),
      .req_second_col(req_second_col), .n_rows(n_rows), .n_cols(n_cols),
      .busy(busy), .cmd(cmd), .row_i(row_i), .row_j(row_j), .col_sel(col_sel),
      .rsp_valid(rsp_valid), .rsp_status(status)
   );

   kgn_dp #(
      .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .RW(RW), .NW(NW), .SUM_W(SUM_W)
   ) u_dp (
      .clock(clock), .load_accept(load_accept), .req_opcode(req_opcode),
      .req_row(req_row), .req_column(req_column), .req_value(req_value),
      .cmd(cmd), .row_i(row_i), .row_j(row_j), .col_sel(col_sel),
      .n_rows(n_rows), .inv_sigma2(sigma_ff), .root(root)
   );

   // an item with a bad column reports a zero norm
   assign rsp_status = status;
   assign rsp_norm   = status ? 32'd0 : root;
endmodule
